>>> sv/rtufgd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RTU frame gap delimiter.
// Used by rtufgd_frame_ctrl, the top level and the checker; depends on nothing.
package rtufgd_pkg;

  // Field widths of the transactions and registers
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned EVENT_W      = 3;
  localparam int unsigned COUNT_W      = 9;
  localparam int unsigned SILENCE_W    = 16;
  localparam int unsigned REPLY_W      = 24;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned CFG_DATA_W   = 24;

  // Input transaction kinds
  localparam logic [REQ_W-1:0] REQ_BYTE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SENT = 2'd2;

  // Result event codes
  localparam logic [EVENT_W-1:0] EV_BYTE      = 3'd0;
  localparam logic [EVENT_W-1:0] EV_COMPLETE  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_SHORT     = 3'd2;
  localparam logic [EVENT_W-1:0] EV_OVERFLOW  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_LIMIT      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESPONSE_LIMIT = 1'd1;

  // Register reset values: 3.5 characters of silence, 100 ms reply window
  localparam logic [SILENCE_W-1:0] GAP_LIMIT_RESET      = 16'd365;
  localparam logic [REPLY_W-1:0]   RESPONSE_LIMIT_RESET = 24'd100000;

  // One result of the frame controller
  typedef struct packed {
    logic                 valid;
    logic [EVENT_W-1:0]   event_code;
    logic [COUNT_W-1:0]   count;
    logic [BYTE_W-1:0]    data;
  } result_t;

endpackage

>>> sv/rtufgd_frame_ctrl.sv
`timescale 1ns / 1ps
// Frame state and counters of the RTU frame gap delimiter.
// Depends on rtufgd_pkg for codes, widths and the result struct.
module rtufgd_frame_ctrl #(
  parameter int unsigned FRAME_LIMIT = 384,
  parameter int unsigned MIN_FRAME   = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [rtufgd_pkg::REQ_W-1:0]       req_type,
  input  logic [rtufgd_pkg::BYTE_W-1:0]      rx_byte,
  input  logic [rtufgd_pkg::SILENCE_W-1:0]   gap_limit,
  input  logic [rtufgd_pkg::REPLY_W-1:0]     response_limit,
  output rtufgd_pkg::result_t                result
);

  localparam int unsigned BCW = $clog2(FRAME_LIMIT + 1);
  localparam logic [BCW-1:0] LAST_IDX = BCW'(FRAME_LIMIT - 1);
  localparam logic [BCW-1:0] MIN_CNT  = BCW'(MIN_FRAME);

  logic                               in_frame, in_frame_next;
  logic [BCW-1:0]                     byte_count, byte_count_next;
  logic [rtufgd_pkg::SILENCE_W-1:0]   silence_ticks, silence_ticks_next;
  logic                               awaiting_reply, awaiting_reply_next;
  logic [rtufgd_pkg::REPLY_W-1:0]     reply_ticks, reply_ticks_next;

  logic [BCW-1:0]                     cur_count;
  logic [rtufgd_pkg::SILENCE_W-1:0]   silence_inc;
  logic [rtufgd_pkg::REPLY_W-1:0]     reply_inc;

  // A byte outside a frame starts counting from zero
  assign cur_count = in_frame ? byte_count : '0;

  // Saturating advances of the two timers on a tick
  assign silence_inc = (in_frame && silence_ticks != '1) ? silence_ticks + 1'b1
                                                         : silence_ticks;
  assign reply_inc   = (awaiting_reply && reply_ticks != '1) ? reply_ticks + 1'b1
                                                             : reply_ticks;

  // Next state and result for the transaction on the input
  always_comb begin
    in_frame_next       = in_frame;
    byte_count_next     = byte_count;
    silence_ticks_next  = silence_ticks;
    awaiting_reply_next = awaiting_reply;
    reply_ticks_next    = reply_ticks;
    result              = '0;
    case (req_type)
      rtufgd_pkg::REQ_BYTE: begin
        silence_ticks_next = '0;
        result.valid       = 1'b1;
        result.data        = rx_byte;
        if (cur_count == LAST_IDX) begin
          // The frame is full: close it with an overflow
          in_frame_next       = 1'b0;
          byte_count_next     = '0;
          awaiting_reply_next = 1'b0;
          result.event_code   = rtufgd_pkg::EV_OVERFLOW;
          result.count        = rtufgd_pkg::COUNT_W'(BCW'(FRAME_LIMIT));
        end else begin
          in_frame_next     = 1'b1;
          byte_count_next   = cur_count + 1'b1;
          result.event_code = rtufgd_pkg::EV_BYTE;
          result.count      = rtufgd_pkg::COUNT_W'(cur_count);
        end
      end
      rtufgd_pkg::REQ_TICK: begin
        silence_ticks_next = silence_inc;
        reply_ticks_next   = reply_inc;
        if (in_frame && silence_inc > gap_limit) begin
          // Silence long enough: the frame has ended
          in_frame_next       = 1'b0;
          byte_count_next     = '0;
          awaiting_reply_next = 1'b0;
          result.valid        = 1'b1;
          result.event_code   = (byte_count >= MIN_CNT) ? rtufgd_pkg::EV_COMPLETE
                                                        : rtufgd_pkg::EV_SHORT;
          result.count        = rtufgd_pkg::COUNT_W'(byte_count);
        end else if (awaiting_reply && reply_inc > response_limit) begin
          // No reply in time: abandon any partial frame
          in_frame_next       = 1'b0;
          byte_count_next     = '0;
          awaiting_reply_next = 1'b0;
          result.valid        = 1'b1;
          result.event_code   = rtufgd_pkg::EV_TIMEOUT;
          result.count        = rtufgd_pkg::COUNT_W'(cur_count);
        end
      end
      rtufgd_pkg::REQ_SENT: begin
        awaiting_reply_next = 1'b1;
        reply_ticks_next    = '0;
      end
      default: begin
      end
    endcase
  end

  // Control state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      byte_count     <= '0;
      silence_ticks  <= '0;
      awaiting_reply <= 1'b0;
      reply_ticks    <= '0;
    end else if (step) begin
      in_frame       <= in_frame_next;
      byte_count     <= byte_count_next;
      silence_ticks  <= silence_ticks_next;
      awaiting_reply <= awaiting_reply_next;
      reply_ticks    <= reply_ticks_next;
    end
  end

endmodule

>>> sv/rtu_frame_gap_delimiter_unit.sv
`timescale 1ns / 1ps
// Top level of the RTU frame gap delimiter: configuration, handshakes, result register.
// Depends on rtufgd_pkg and rtufgd_frame_ctrl.
//
// Receive-side framing for an RTU master. Each input transaction is a
// received byte, a one-microsecond tick or a "request sent" event, chosen by
// req_type. A byte yields a result with its index in the frame (or an
// overflow at the frame limit); a tick may yield a frame end (complete or
// too short) or a response timeout; other transactions yield nothing.
// Both channels use valid/ready. A transaction is handled in the cycle it
// is accepted and its result appears on the output in the cycle after,
// and one transaction is taken every cycle while the output is not stalled.
// The single output register sets the pace: in_ready is high while that
// register is empty or being drained, so a stalled receiver holds back the
// input only while a result is waiting.
// Registers are written through cfg_we/cfg_index/cfg_data without a wait.
// Reset clears the frame state and timers, empties the output register and
// restores the gap and response limits to their defaults.
module rtu_frame_gap_delimiter_unit #(
  parameter int unsigned FRAME_LIMIT = 384,
  parameter int unsigned MIN_FRAME   = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rtufgd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rtufgd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rtufgd_pkg::REQ_W-1:0]         req_type,
  input  logic [rtufgd_pkg::BYTE_W-1:0]        rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rtufgd_pkg::EVENT_W-1:0]       event_res,
  output logic [rtufgd_pkg::COUNT_W-1:0]       count,
  output logic [rtufgd_pkg::BYTE_W-1:0]        out_byte
);

  logic [rtufgd_pkg::SILENCE_W-1:0] gap_limit;
  logic [rtufgd_pkg::REPLY_W-1:0]   response_limit;
  logic                             step;
  rtufgd_pkg::result_t              result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit      <= rtufgd_pkg::GAP_LIMIT_RESET;
      response_limit <= rtufgd_pkg::RESPONSE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rtufgd_pkg::CFG_GAP_LIMIT:
          gap_limit <= cfg_data[rtufgd_pkg::SILENCE_W-1:0];
        rtufgd_pkg::CFG_RESPONSE_LIMIT:
          response_limit <= cfg_data[rtufgd_pkg::REPLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input is taken whenever the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  rtufgd_frame_ctrl #(
    .FRAME_LIMIT (FRAME_LIMIT),
    .MIN_FRAME   (MIN_FRAME)
  ) u_frame_ctrl (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .req_type       (req_type),
    .rx_byte        (rx_byte),
    .gap_limit      (gap_limit),
    .response_limit (response_limit),
    .result         (result)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      event_res <= result.event_code;
      count     <= result.count;
      out_byte  <= result.data;
    end
  end

endmodule

>>> sv/rtufgd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the RTU frame gap delimiter, bound to the top level.
// Depends on rtufgd_pkg for event codes and widths.
module rtufgd_checker #(
  parameter int unsigned MIN_FRAME = 4
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [rtufgd_pkg::EVENT_W-1:0]     event_res,
  input logic [rtufgd_pkg::COUNT_W-1:0]     count,
  input logic [rtufgd_pkg::BYTE_W-1:0]      out_byte
);

  // Reset leaves the result register empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(count)
      && $stable(out_byte))
    else $error("stalled result changed");

  // A waiting result blocks new transactions
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // Frame end and timeout events carry no byte
  a_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == rtufgd_pkg::EV_COMPLETE || event_res == rtufgd_pkg::EV_SHORT
      || event_res == rtufgd_pkg::EV_TIMEOUT) |-> out_byte == '0)
    else $error("byte reported with a frame end event");

  // A too-short frame reports fewer bytes than the minimum
  a_short_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == rtufgd_pkg::EV_SHORT
      |-> count < rtufgd_pkg::COUNT_W'(MIN_FRAME))
    else $error("too-short frame with enough bytes");

endmodule

bind rtu_frame_gap_delimiter_unit rtufgd_checker #(
  .MIN_FRAME (MIN_FRAME)
) u_rtufgd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .event_res (event_res),
  .count     (count),
  .out_byte  (out_byte)
);
